/* rtl/core/ramr_pkg.sv */
// Package for the rational add/multiply/reduce core.
// Widths and shared types; no dependencies.
`timescale 1ns / 1ps
package ramr_pkg;
  localparam int OPERAND_WIDTH = 16;
  localparam int PROD_W = 2 * OPERAND_WIDTH;
  localparam int MAG_W = PROD_W + 1;
  localparam int CNT_W = $clog2(MAG_W + 1);
  localparam int NUM_W = 33;
  localparam int DEN_W = 32;

  typedef logic [MAG_W-1:0] mag_t;

  typedef struct packed {
    logic start;
    mag_t dividend;
    mag_t divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    mag_t quot;
    mag_t rem;
  } div_rsp_t;
endpackage

/* rtl/core/ramr_if.sv */
// Valid/ready channel interfaces for the rational core.
// No dependencies.
`timescale 1ns / 1ps
interface ramr_in_if;
  logic valid;
  logic ready;
  logic mode;
  logic signed [15:0] a_num;
  logic signed [15:0] a_den;
  logic signed [15:0] b_num;
  logic signed [15:0] b_den;
  modport source(output valid, mode, a_num, a_den, b_num, b_den, input ready);
  modport sink(input valid, mode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface ramr_out_if;
  logic valid;
  logic ready;
  logic signed [32:0] result_num;
  logic signed [31:0] result_den;
  logic zero_fault;
  modport source(output valid, result_num, result_den, zero_fault, input ready);
  modport sink(input valid, result_num, result_den, zero_fault, output ready);
endinterface

/* rtl/core/ramr_div.sv */
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
// Depends on ramr_pkg.
`timescale 1ns / 1ps
module ramr_div (
  input  logic              clk,
  input  logic              rst_n,
  input  ramr_pkg::div_req_t req,
  output ramr_pkg::div_rsp_t rsp
);
  import ramr_pkg::*;

  mag_t q_r, q_nxt, r_r, r_nxt, d_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [MAG_W:0] trial;

  always_comb begin
    q_nxt = q_r;
    r_nxt = r_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {r_r, q_r[MAG_W-1]} - {1'b0, d_r};
    if (req.start) begin
      q_nxt = req.dividend;
      r_nxt = '0;
      cnt_nxt = CNT_W'(MAG_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[MAG_W]) r_nxt = trial[MAG_W-1:0];
      else r_nxt = {r_r[MAG_W-2:0], q_r[MAG_W-1]};
      q_nxt = {q_r[MAG_W-2:0], ~trial[MAG_W]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    if (req.start) d_r <= req.divisor;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem = r_r;

  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("divider done while busy");
  assert property (@(posedge clk) disable iff (!rst_n) req.start |=> busy_r)
    else $error("divider failed to start");
  assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && cnt_r == CNT_W'(1) |=> done_r)
    else $error("divider missed done");
endmodule

/* rtl/core/rational_add_mul_reduce_core.sv */
// Top level of the rational add/multiply core with Euclid reduction.
// Depends on ramr_pkg, ramr_if and ramr_div.
//
// Usage: one input beat carries mode and two signed 16-bit fractions; one
// result beat follows with the reduced numerator/denominator and a fault
// flag set for 0/0. Mode 0 adds, mode 1 multiplies.
// Steps per item: three products in turn on one shared multiplier, then the
// sum. Then come k Euclid remainder steps and two exact divisions on the
// shared bit-serial divider, each a start state and a wait for done, plus
// the final zero test of the remainder. 0/0 skips the divider. One item is
// in flight at a time and in_ready is low meanwhile; the next beat is taken
// only once the result has been accepted.
// The result sits in an output register until taken; a stalled receiver
// holds it and blocks the next item. Reset clears the control state and
// drops any item in progress.
`timescale 1ns / 1ps
module rational_add_mul_reduce_core (
  input logic clk,
  input logic rst_n,
  ramr_in_if.sink in_ch,
  ramr_out_if.source out_ch
);
  import ramr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_SUM, S_EUC, S_EUCW, S_DIVN, S_DIVNW, S_DIVD,
    S_DIVDW, S_OUT
  } state_t;

  state_t state_r;
  logic mode_r;
  logic signed [OPERAND_WIDTH-1:0] an_r, ad_r, bn_r, bd_r;
  logic signed [PROD_W-1:0] p1_r, p2_r, p3_r;
  logic signed [MAG_W:0] n_s, d_s;
  logic ns_r, ds_r, gs_r, hs_r;
  mag_t nm_r, dm_r, gm_r, hm_r;
  logic signed [NUM_W-1:0] onum_r;
  logic signed [DEN_W-1:0] oden_r;
  logic ofault_r, ovalid_r;
  div_req_t dreq;
  div_rsp_t drsp;
  logic signed [PROD_W-1:0] mul_a, mul_b, prod;
  mag_t quot_s;

  ramr_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // one shared multiplier
  always_comb begin
    mul_a = PROD_W'(an_r);
    mul_b = mode_r ? PROD_W'(bn_r) : PROD_W'(bd_r);
    if (state_r == S_MUL2) begin
      mul_a = PROD_W'(ad_r);
      mul_b = PROD_W'(bn_r);
    end else if (state_r == S_MUL3) begin
      mul_a = PROD_W'(ad_r);
      mul_b = PROD_W'(bd_r);
    end
    prod = mul_a * mul_b;
  end

  always_comb begin
    n_s = (MAG_W+1)'(p1_r);
    if (!mode_r) n_s = (MAG_W+1)'(p1_r) + (MAG_W+1)'(p2_r);
    d_s = (MAG_W+1)'(p3_r);
  end

  always_comb begin
    dreq.start = 1'b0;
    dreq.dividend = gm_r;
    dreq.divisor = hm_r;
    case (state_r)
      S_EUC: dreq.start = 1'b1;
      S_DIVN: begin
        dreq.start = 1'b1;
        dreq.dividend = nm_r;
        dreq.divisor = gm_r;
      end
      S_DIVD: begin
        dreq.start = 1'b1;
        dreq.dividend = dm_r;
        dreq.divisor = gm_r;
      end
      default: ;
    endcase
    quot_s = drsp.quot;
  end

  assign in_ch.ready = (state_r == S_IDLE) && !ovalid_r;
  assign out_ch.valid = ovalid_r;
  assign out_ch.result_num = onum_r;
  assign out_ch.result_den = oden_r;
  assign out_ch.zero_fault = ofault_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      if (state_r == S_OUT) ovalid_r <= 1'b1;
      else if (out_ch.valid && out_ch.ready) ovalid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          mode_r <= in_ch.mode;
          an_r <= in_ch.a_num;
          ad_r <= in_ch.a_den;
          bn_r <= in_ch.b_num;
          bd_r <= in_ch.b_den;
          state_r <= S_MUL1;
        end
        S_MUL1: begin
          p1_r <= prod;
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          p2_r <= prod;
          state_r <= S_MUL3;
        end
        S_MUL3: begin
          p3_r <= prod;
          state_r <= S_SUM;
        end
        S_SUM: begin
          ns_r <= n_s[MAG_W];
          ds_r <= d_s[MAG_W];
          nm_r <= n_s[MAG_W] ? MAG_W'(-n_s) : MAG_W'(n_s);
          dm_r <= d_s[MAG_W] ? MAG_W'(-d_s) : MAG_W'(d_s);
          gs_r <= n_s[MAG_W];
          hs_r <= d_s[MAG_W];
          gm_r <= n_s[MAG_W] ? MAG_W'(-n_s) : MAG_W'(n_s);
          hm_r <= d_s[MAG_W] ? MAG_W'(-d_s) : MAG_W'(d_s);
          state_r <= S_EUC;
          if (n_s == '0 && d_s == '0) begin
            onum_r <= '0;
            oden_r <= '0;
            ofault_r <= 1'b1;
            state_r <= S_OUT;
          end
        end
        S_EUC: if (hm_r == '0) state_r <= S_DIVN;
               else state_r <= S_EUCW;
        S_EUCW: if (drsp.done) begin
          // g = h, h = g rem h keeping the dividend's sign
          gm_r <= hm_r;
          gs_r <= hs_r;
          hm_r <= drsp.rem;
          hs_r <= (drsp.rem != '0) && gs_r;
          state_r <= S_EUC;
        end
        S_DIVN: state_r <= S_DIVNW;
        S_DIVNW: if (drsp.done) begin
          onum_r <= (ns_r != gs_r) ? NUM_W'(-quot_s) : NUM_W'(quot_s);
          state_r <= S_DIVD;
        end
        S_DIVD: state_r <= S_DIVDW;
        S_DIVDW: if (drsp.done) begin
          oden_r <= (ds_r != gs_r) ? DEN_W'(-quot_s) : DEN_W'(quot_s);
          ofault_r <= 1'b0;
          state_r <= S_OUT;
        end
        S_OUT: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r == S_MUL1)
    else $error("accepted beat not started");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && ofault_r |-> onum_r == '0 && oden_r == '0)
    else $error("fault with nonzero result");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EUCW && drsp.done |-> drsp.rem < hm_r)
    else $error("remainder not below divisor");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(onum_r) && $stable(oden_r))
    else $error("result changed while stalled");
endmodule

/* tb/rational_add_mul_reduce_core_tb.sv */
// Testbench for rational_add_mul_reduce_core: add/multiply of signed fractions
// with Euclid reduction, checked beat by beat against an in-bench predictor.
// Depends on ramr_pkg, ramr_if and the core RTL.
`timescale 1ns / 1ps
module rational_add_mul_reduce_core_tb;
  import ramr_pkg::*;

  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_MUL = 1'b1;

  typedef struct {
    logic mode;
    logic signed [15:0] a_num;
    logic signed [15:0] a_den;
    logic signed [15:0] b_num;
    logic signed [15:0] b_den;
  } frac_op_t;

  typedef struct {
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
    logic fault;
  } frac_res_t;

  typedef struct {
    frac_op_t op;
    bit known;
    frac_res_t res;
  } op_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int errors = 0;
  bit no_idle = 1'b0;
  frac_res_t pending_fracs[$];

  ramr_in_if in_if();
  ramr_out_if out_if();

  rational_add_mul_reduce_core DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_if),
    .out_ch(out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #100ms;
    $display("rational_add_mul_reduce_core_tb NOT OK");
    $finish;
  end

  function automatic frac_res_t reduce_fraction(frac_op_t op);
    frac_res_t res;
    longint n, d, g, h, r;
    if (op.mode == MODE_MUL) n = longint'(op.a_num) * longint'(op.b_num);
    else n = longint'(op.a_num) * longint'(op.b_den) + longint'(op.a_den) * longint'(op.b_num);
    d = longint'(op.a_den) * longint'(op.b_den);
    if (n == 0 && d == 0) begin
      res.num = '0;
      res.den = '0;
      res.fault = 1'b1;
      return res;
    end
    g = n;
    h = d;
    // remainder truncates toward zero, so g may end negative and flip both signs
    while (h != 0) begin
      r = g % h;
      g = h;
      h = r;
    end
    res.num = NUM_W'(n / g);
    res.den = DEN_W'(d / g);
    res.fault = 1'b0;
    return res;
  endfunction

  function automatic op_row_t row(logic m, int an, int ad, int bn, int bd, bit known = 0,
                                  longint en = 0, longint ed = 0, bit ef = 0);
    op_row_t t;
    t.op.mode = m;
    t.op.a_num = 16'(an);
    t.op.a_den = 16'(ad);
    t.op.b_num = 16'(bn);
    t.op.b_den = 16'(bd);
    t.known = known;
    t.res.num = NUM_W'(en);
    t.res.den = DEN_W'(ed);
    t.res.fault = ef;
    return t;
  endfunction

  task automatic send_op(op_row_t t);
    while (!no_idle && $urandom_range(99) < 12) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.mode <= t.op.mode;
    in_if.a_num <= t.op.a_num;
    in_if.a_den <= t.op.a_den;
    in_if.b_num <= t.op.b_num;
    in_if.b_den <= t.op.b_den;
    do @(posedge clk); while (!in_if.ready);
    pending_fracs.push_back(t.known ? t.res : reduce_fraction(t.op));
    @(negedge clk);
  endtask

  function automatic logic signed [15:0] rand_operand();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(20)) - 10);
      2: return $urandom_range(1) ? 16'sh7fff - 16'($urandom_range(3)) :
                                    16'sh8000 + 16'($urandom_range(3));
      default: return 16'($signed($urandom_range(512)) - 256);
    endcase
  endfunction

  // result side: random back-pressure, compare every accepted beat
  always @(negedge clk) begin
    out_if.ready <= no_idle || ($urandom_range(99) >= 12);
  end

  always @(posedge clk) begin
    frac_res_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_fracs.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = pending_fracs.pop_front();
        if (out_if.result_num !== e.num) begin
          $error("result_num expected %0d actual %0d", e.num, out_if.result_num);
          errors++;
        end
        if (out_if.result_den !== e.den) begin
          $error("result_den expected %0d actual %0d", e.den, out_if.result_den);
          errors++;
        end
        if (out_if.zero_fault !== e.fault) begin
          $error("zero_fault expected %0b actual %0b", e.fault, out_if.zero_fault);
          errors++;
        end
      end
    end
  end

  initial begin
    op_row_t directed[$];
    op_row_t t;
    in_if.valid = 1'b0;
    in_if.mode = MODE_ADD;
    in_if.a_num = '0;
    in_if.a_den = '0;
    in_if.b_num = '0;
    in_if.b_den = '0;
    out_if.ready = 1'b0;

    directed = '{
      row(MODE_ADD, 0, 0, 0, 0, 1, 0, 0, 1),
      row(MODE_MUL, 0, 0, 5, 0, 1, 0, 0, 1),
      row(MODE_MUL, 5, 0, 3, 1, 1, 1, 0, 0),
      row(MODE_ADD, 7, 3, 2, 0, 1, 1, 0, 0),
      row(MODE_MUL, 0, 3, 5, 7, 1, 0, 1, 0),
      row(MODE_ADD, 0, 4, 0, -9, 1, 0, 1, 0),
      row(MODE_MUL, -32768, -32768, -32768, -32768, 1, 1, 1, 0),
      row(MODE_ADD, -32768, 1, -32768, 1, 1, -65536, 1, 0),
      row(MODE_ADD, 32767, 1, 32767, 1, 1, 65534, 1, 0),
      row(MODE_MUL, 1, -1, 1, 1, 1, -1, 1, 0),
      row(MODE_ADD, -32768, -32768, -32768, -32768),
      row(MODE_ADD, 32767, -32768, 32767, -32768),
      row(MODE_MUL, 32767, 32767, -32768, 1),
      row(MODE_ADD, 1, 2, 1, 3),
      row(MODE_ADD, 1, 2, -1, 2),
      row(MODE_ADD, 3, -4, 5, 6),
      row(MODE_MUL, -6, 4, 10, -15),
      row(MODE_MUL, 12345, -23456, -31111, 29999),
      row(MODE_ADD, 32767, 32766, 32765, 32764),
      row(MODE_ADD, -1, -1, -1, -1),
      row(MODE_MUL, 21, 34, 55, 89)
    };

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) send_op(directed[i]);

    for (int i = 0; i < 750; i++) begin
      no_idle = (i >= 300 && i < 420);
      t.op.mode = 1'($urandom);
      t.op.a_num = rand_operand();
      t.op.a_den = rand_operand();
      t.op.b_num = rand_operand();
      t.op.b_den = rand_operand();
      if ($urandom_range(19) == 0) t.op.a_den = '0;
      if ($urandom_range(19) == 0) t.op.b_num = '0;
      t.known = 1'b0;
      send_op(t);
    end
    in_if.valid <= 1'b0;

    while (pending_fracs.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("rational_add_mul_reduce_core_tb OK");
    end else begin
      $display("rational_add_mul_reduce_core_tb NOT OK");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/core/ramr_pkg.sv
rtl/core/ramr_if.sv
rtl/core/ramr_div.sv
rtl/core/rational_add_mul_reduce_core.sv
tb/rational_add_mul_reduce_core_tb.sv
